@@ rtl/assert_macros.svh @@
// Assertion helper macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/nfba_pkg.sv @@
// ----------------------------------------------------------------------------
// nfba_pkg
// Types and constants for the next-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfba_pkg;

  localparam int ARENA_WORDS    = 1024;
  localparam int IDX_W          = $clog2(ARENA_WORDS);
  localparam int STEP_W         = IDX_W + 1;
  localparam int HDR_BYTES      = 8;
  localparam int MIN_USER_BYTES = 8;
  // remainder (words) needed to split off a new free block
  localparam int SPLIT_MIN_WORDS = (HDR_BYTES + MIN_USER_BYTES + 7) / 8;
  // minimum arena span (words) for ring setup
  localparam int SETUP_MIN_WORDS = (2 * HDR_BYTES + MIN_USER_BYTES + 7) / 8;

  localparam int ADDR_W = 13;
  localparam int REG_W  = 14;
  localparam int CFG_IDX_W = 1;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_END   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_DBL_FREE  = 2'd2;
  localparam logic [1:0] ST_NOT_SETUP = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] release_address;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] user_address;
  } out_rsp_t;

  // header word: next block index and free flag
  typedef struct packed {
    logic [IDX_W-1:0] next;
    logic             free;
  } hdr_t;

endpackage

`default_nettype wire

@@ rtl/next_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator with coalescing over a header ring held in block RAM.
// ----------------------------------------------------------------------------
// One request is in flight at a time; in_stall stays high until its result is
// taken. A free reads and updates the block header (S_FREE_RD, S_FREE_EV), then
// checks a successor that lies above it in a second S_FREE_EV pass; a free of
// address zero or one made before the ring is built goes straight to S_RESP.
// An allocate walks the header ring through the single RAM read port: each
// block is read and evaluated (S_WALK_RD, S_WALK_EV); an allocated one is
// stepped past in S_ADV, a free one absorbs free successors above it in
// S_MERGE; S_FIT then takes it, split in S_SPLIT if big enough, or steps on.
// The first allocate builds the ring (S_SETUP_A, S_SETUP_B). A search gives
// up back at its start block or after ARENA_WORDS + 1 blocks. No clearing is needed.
`default_nettype none

module next_fit_block_allocator (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  nfba_pkg::in_req_t            in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output nfba_pkg::out_rsp_t           out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [nfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [nfba_pkg::REG_W-1:0]    cfg_data
);
  import nfba_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_SETUP_A = 12'b000000000010,
    S_SETUP_B = 12'b000000000100,
    S_WALK_RD = 12'b000000001000,
    S_WALK_EV = 12'b000000010000,
    S_MERGE   = 12'b000000100000,
    S_FIT     = 12'b000001000000,
    S_SPLIT   = 12'b000010000000,
    S_ADV     = 12'b000100000000,
    S_FREE_RD = 12'b001000000000,
    S_FREE_EV = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [REG_W-1:0]  start_byte_r, start_byte_nxt;
  logic [REG_W-1:0]  end_byte_r, end_byte_nxt;
  logic              ring_ready_r, ring_ready_nxt;
  logic [IDX_W-1:0]  rover_r, rover_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  nx_r, nx_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [STEP_W-1:0] req_r, req_nxt;
  logic              frmerge_r, frmerge_nxt;
  out_rsp_t          rsp_r, rsp_nxt;

  // header RAM
  hdr_t             mem [ARENA_WORDS];
  hdr_t             rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  hdr_t             wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // setup bounds from config
  logic [IDX_W+1:0] sw_c;
  logic [IDX_W:0]   ew_raw_c;
  logic [IDX_W:0]   ew_c;
  logic             setup_ok_c;
  logic [IDX_W:0]   last_c;

  always_comb begin
    sw_c       = (IDX_W+2)'(({1'b0, start_byte_r} + 15'd7) >> 3);
    ew_raw_c   = end_byte_r[REG_W-1:3];
    ew_c       = (ew_raw_c > (IDX_W+1)'(ARENA_WORDS)) ? (IDX_W+1)'(ARENA_WORDS) : ew_raw_c;
    setup_ok_c = ({1'b0, sw_c} + (IDX_W+3)'(SETUP_MIN_WORDS)) <= {2'b00, ew_c};
    last_c     = ew_c - 1'b1;
  end

  // fit check on the current candidate
  logic [STEP_W-1:0] size_c;
  logic [STEP_W-1:0] rem_c;
  logic [IDX_W-1:0]  nb_c;
  logic [IDX_W-1:0]  wfree_c;

  always_comb begin
    size_c  = (nx_r > cur_r) ? ({1'b0, nx_r} - {1'b0, cur_r} - 1'b1) : '0;
    rem_c   = size_c - req_r;
    nb_c    = IDX_W'({1'b0, cur_r} + req_r + 1'b1);
    wfree_c = in_data.release_address[ADDR_W-1:3];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign out_data  = rsp_r;
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    start_byte_nxt = start_byte_r;
    end_byte_nxt   = end_byte_r;
    ring_ready_nxt = ring_ready_r;
    rover_nxt      = rover_r;
    cur_nxt        = cur_r;
    nx_nxt         = nx_r;
    start_nxt      = start_r;
    steps_nxt      = steps_r;
    req_nxt        = req_r;
    frmerge_nxt    = frmerge_r;
    rsp_nxt        = rsp_r;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = '{next: nx_r, free: 1'b1};

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ARENA_START: start_byte_nxt = cfg_data;
        CFG_ARENA_END:   end_byte_nxt   = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rsp_nxt = '{status: ST_OK, user_address: '0};
          req_nxt = STEP_W'(({1'b0, in_data.request_bytes} + 14'd7) >> 3);
          if (in_data.mode == MODE_ALLOC) begin
            if (ring_ready_r) begin
              cur_nxt   = rover_r;
              start_nxt = rover_r;
              steps_nxt = '0;
              state_nxt = S_WALK_RD;
            end else if (setup_ok_c) begin
              cur_nxt   = sw_c[IDX_W-1:0];
              nx_nxt    = last_c[IDX_W-1:0];
              state_nxt = S_SETUP_A;
            end else begin
              rsp_nxt.status = ST_NOT_SETUP;
              state_nxt      = S_RESP;
            end
          end else begin
            if (!ring_ready_r) begin
              rsp_nxt.status = ST_NOT_SETUP;
              state_nxt      = S_RESP;
            end else if (wfree_c == '0) begin
              state_nxt = S_RESP;
            end else begin
              cur_nxt     = wfree_c - 1'b1;
              frmerge_nxt = 1'b0;
              state_nxt   = S_FREE_RD;
            end
          end
        end
      end

      // first block spans the arena, dummy block sits in the last word
      S_SETUP_A: begin
        wr_en     = 1'b1;
        wr_addr   = cur_r;
        wr_data   = '{next: nx_r, free: 1'b1};
        state_nxt = S_SETUP_B;
      end

      S_SETUP_B: begin
        wr_en          = 1'b1;
        wr_addr        = nx_r;
        wr_data        = '{next: cur_r, free: 1'b0};
        rover_nxt      = cur_r;
        ring_ready_nxt = 1'b1;
        start_nxt      = cur_r;
        steps_nxt      = '0;
        state_nxt      = S_WALK_RD;
      end

      S_WALK_RD: begin
        rd_addr   = cur_r;
        state_nxt = S_WALK_EV;
      end

      S_WALK_EV: begin
        nx_nxt = rd_data_r.next;
        if (!rd_data_r.free) begin
          state_nxt = S_ADV;
        end else if (rd_data_r.next > cur_r) begin
          rd_addr   = rd_data_r.next;
          state_nxt = S_MERGE;
        end else begin
          state_nxt = S_FIT;
        end
      end

      // absorb free successors one at a time
      S_MERGE: begin
        if (rd_data_r.free && (rd_data_r.next > nx_r)) begin
          if (nx_r == start_r) begin
            start_nxt = cur_r;
          end
          nx_nxt  = rd_data_r.next;
          wr_en   = 1'b1;
          wr_addr = cur_r;
          wr_data = '{next: rd_data_r.next, free: 1'b1};
          rd_addr = rd_data_r.next;
        end else begin
          state_nxt = S_FIT;
        end
      end

      S_FIT: begin
        if (size_c >= req_r) begin
          rsp_nxt.user_address = {cur_r + 1'b1, 3'b000};
          wr_en = 1'b1;
          if (rem_c < STEP_W'(SPLIT_MIN_WORDS)) begin
            wr_addr   = cur_r;
            wr_data   = '{next: nx_r, free: 1'b0};
            rover_nxt = nx_r;
            state_nxt = S_RESP;
          end else begin
            wr_addr   = nb_c;
            wr_data   = '{next: nx_r, free: 1'b1};
            nx_nxt    = nb_c;
            state_nxt = S_SPLIT;
          end
        end else begin
          state_nxt = S_ADV;
        end
      end

      S_SPLIT: begin
        wr_en     = 1'b1;
        wr_addr   = cur_r;
        wr_data   = '{next: nx_r, free: 1'b0};
        rover_nxt = nx_r;
        state_nxt = S_RESP;
      end

      // step to next block or give up
      S_ADV: begin
        cur_nxt   = nx_r;
        steps_nxt = steps_r + 1'b1;
        if ((nx_r == start_r) || (steps_r == STEP_W'(ARENA_WORDS))) begin
          rover_nxt      = start_r;
          rsp_nxt.status = ST_NO_FIT;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end

      S_FREE_RD: begin
        rd_addr   = cur_r;
        state_nxt = S_FREE_EV;
      end

      // first pass: header of block; second pass: its successor
      S_FREE_EV: begin
        if (!frmerge_r) begin
          if (rd_data_r.free) begin
            rsp_nxt.status = ST_DBL_FREE;
            state_nxt      = S_RESP;
          end else begin
            nx_nxt  = rd_data_r.next;
            wr_en   = 1'b1;
            wr_addr = cur_r;
            wr_data = '{next: rd_data_r.next, free: 1'b1};
            if (rd_data_r.next > cur_r) begin
              rd_addr     = rd_data_r.next;
              frmerge_nxt = 1'b1;
            end else begin
              state_nxt = S_RESP;
            end
          end
        end else begin
          if (rd_data_r.free && (rd_data_r.next > nx_r)) begin
            wr_en   = 1'b1;
            wr_addr = cur_r;
            wr_data = '{next: rd_data_r.next, free: 1'b1};
            if (rover_r == nx_r) begin
              rover_nxt = cur_r;
            end
          end
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_byte_r <= '0;
      end_byte_r   <= REG_W'(8192);
      ring_ready_r <= 1'b0;
      rover_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      start_byte_r <= start_byte_nxt;
      end_byte_r   <= end_byte_nxt;
      ring_ready_r <= ring_ready_nxt;
      rover_r      <= rover_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    nx_r      <= nx_nxt;
    start_r   <= start_nxt;
    steps_r   <= steps_nxt;
    req_r     <= req_nxt;
    frmerge_r <= frmerge_nxt;
    rsp_r     <= rsp_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/nfba_checker.sv @@
// ----------------------------------------------------------------------------
// nfba_checker
// Port-level checks for the next-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nfba_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input nfba_pkg::out_rsp_t out_data
);
  import nfba_pkg::*;

  // held result does not change
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // no new request while a result is pending
  `CHK_SAME(a_busy, clk, rst_n, out_valid, in_stall)
  // failed requests return no address
  `CHK_SAME(a_zero, clk, rst_n, out_valid && (out_data.status != ST_OK), out_data.user_address == '0)
  // addresses are word aligned
  `CHK_SAME(a_align, clk, rst_n, out_valid, out_data.user_address[2:0] == 3'b000)

endmodule

bind next_fit_block_allocator nfba_checker u_nfba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
